[rtl/core/acs_pkg.sv]
// ============================================================================
// acs_pkg
// Shared constants and types for the cumulative-sum core.
// ============================================================================
package acs_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int MAX_INNER_DEF  = 1024;
    localparam int MAX_RANK       = 4;

    localparam int ELEM_WIDTH     = 64;
    localparam int DIM_WIDTH      = 13;
    localparam int NUM_DIMS       = 4;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 13;
    localparam int AXIS_WIDTH     = 3;
    localparam int RANK_WIDTH     = 3;
    localparam int SETTLE_CYCLES  = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_FLATTEN_MODE = 3'd0,
        CFG_AXIS         = 3'd1,
        CFG_RANK         = 3'd2,
        CFG_DIM_ZERO     = 3'd3,
        CFG_DIM_ONE      = 3'd4,
        CFG_DIM_TWO      = 3'd5,
        CFG_DIM_THREE    = 3'd6
    } cfg_index_t;

    typedef logic [DIM_WIDTH-1:0] dim_t;

endpackage

[rtl/core/axis_cumulative_sum_core.sv]
// ============================================================================
// axis_cumulative_sum_core
// Running sum of a streamed array along one axis, or over the flattened array.
// ============================================================================
// Usage:
//   Elements enter on the item channel (item_valid / item_stall) in row-major
//   order, end_of_array marking the last one. Each element yields one word on
//   the result channel (result_valid / result_stall): sum, final_res and
//   shape_error.
//   result_valid rises once the element has passed the two register stages,
//   stage 1 and the result register; one element is taken every cycle while
//   item_stall is low. The partial-sum line store has one read port
//   (registered) and one write port; a write hitting the address read in the
//   same cycle is forwarded. A configuration write goes through a three-stage
//   shape decode (two multiplies for the inner size), so item_stall stays
//   high after each write and after reset until the settle count runs out.
//   Reset clears the positions, the flattened sum and the output valid; the
//   line store is not cleared.
//   While result_stall is high the result word holds; one more element may
//   enter the internal stage, after which item_stall rises.
// ============================================================================
module axis_cumulative_sum_core
    import acs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_INNER  = MAX_INNER_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [ELEM_WIDTH-1:0]  element,
    input  logic                          end_of_array,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [ELEM_WIDTH-1:0]  sum,
    output logic                          final_res,
    output logic                          shape_error
);

    localparam int AW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CLAMP = MAX_INNER + 1;
    localparam int IW    = $clog2(MAX_INNER + 2);
    localparam int CW    = (IW > DIM_WIDTH) ? IW : DIM_WIDTH;
    localparam int PW    = 2 * IW;
    localparam int SW    = $clog2(SETTLE_CYCLES + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                          flatten_reg, flatten_next;
    logic signed [AXIS_WIDTH-1:0]  axis_reg, axis_next;
    logic [RANK_WIDTH-1:0]         rank_reg, rank_next;
    dim_t                          dim_reg [NUM_DIMS];
    dim_t                          dim_next [NUM_DIMS];
    logic [SW-1:0]                 settle_reg, settle_next;

    always_comb
    begin
        flatten_next = flatten_reg;
        axis_next    = axis_reg;
        rank_next    = rank_reg;
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            dim_next[i] = dim_reg[i];
        end
        settle_next  = (settle_reg != '0) ? settle_reg - SW'(1) : settle_reg;
        if (cfg_write)
        begin
            settle_next = SW'(SETTLE_CYCLES);
            case (cfg_index)
                CFG_FLATTEN_MODE: flatten_next = cfg_data[0];
                CFG_AXIS:         axis_next    = cfg_data[AXIS_WIDTH-1:0];
                CFG_RANK:         rank_next    = cfg_data[RANK_WIDTH-1:0];
                CFG_DIM_ZERO:     dim_next[0]  = cfg_data[DIM_WIDTH-1:0];
                CFG_DIM_ONE:      dim_next[1]  = cfg_data[DIM_WIDTH-1:0];
                CFG_DIM_TWO:      dim_next[2]  = cfg_data[DIM_WIDTH-1:0];
                CFG_DIM_THREE:    dim_next[3]  = cfg_data[DIM_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flatten_reg <= 1'b1;
            axis_reg    <= '0;
            rank_reg    <= RANK_WIDTH'(1);
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                dim_reg[i] <= DIM_WIDTH'(1);
            end
            settle_reg  <= SW'(SETTLE_CYCLES);
        end
        else
        begin
            flatten_reg <= flatten_next;
            axis_reg    <= axis_next;
            rank_reg    <= rank_next;
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                dim_reg[i] <= dim_next[i];
            end
            settle_reg  <= settle_next;
        end
    end

    // ------------------------------------------------------------------
    // shape decode: axis, factors, inner size
    // ------------------------------------------------------------------
    function automatic dim_t dim_at(input logic [3:0] j, input dim_t d0, input dim_t d1,
                                    input dim_t d2, input dim_t d3);
        dim_t d;
        begin
            case (j)
                4'd0:    d = d0;
                4'd1:    d = d1;
                4'd2:    d = d2;
                4'd3:    d = d3;
                default: d = DIM_WIDTH'(1);
            endcase
            dim_at = (d == '0) ? DIM_WIDTH'(1) : d;
        end
    endfunction

    function automatic logic [IW-1:0] clamp_dim(input dim_t d);
        logic [CW-1:0] e;
        begin
            e = CW'(d);
            clamp_dim = (e > CW'(CLAMP)) ? IW'(CLAMP) : IW'(e);
        end
    endfunction

    function automatic logic [IW-1:0] clamp_prod(input logic [PW-1:0] p);
        begin
            clamp_prod = (p > PW'(CLAMP)) ? IW'(CLAMP) : IW'(p);
        end
    endfunction

    logic signed [4:0]  axis_ext, rank_ext, axis_res;
    logic               dec_err;
    logic [3:0]         ax_idx;
    logic [3:0]         fac_idx [3];
    logic [IW-1:0]      fac [3];

    logic               a_err_reg, a_err_next;
    dim_t               a_size_reg, a_size_next;
    logic [IW-1:0]      a_fac_reg [3];
    logic [IW-1:0]      a_fac_next [3];

    logic               b_err_reg, b_err_next;
    dim_t               b_size_reg, b_size_next;
    logic [IW-1:0]      b_p12_reg, b_p12_next;
    logic [IW-1:0]      b_f3_reg, b_f3_next;

    logic               c_err_reg, c_err_next;
    dim_t               c_size_reg, c_size_next;
    logic [IW-1:0]      c_inner_reg, c_inner_next;
    logic [IW-1:0]      c_inner_full;

    always_comb
    begin
        axis_ext = 5'(axis_reg);
        rank_ext = $signed({2'b00, rank_reg});
        axis_res = (axis_ext < 0) ? axis_ext + rank_ext : axis_ext;
        dec_err  = (rank_reg == '0) || ({1'b0, rank_reg} > 4'(MAX_RANK))
                   || (axis_res < 0) || (axis_res >= rank_ext);
        ax_idx   = axis_res[3:0];
        for (int i = 0; i < 3; i++)
        begin
            fac_idx[i] = ax_idx + 4'(i + 1);
            fac[i]     = ({1'b0, fac_idx[i]} < {2'b00, rank_reg})
                         ? clamp_dim(dim_at(fac_idx[i], dim_reg[0], dim_reg[1],
                                            dim_reg[2], dim_reg[3]))
                         : IW'(1);
        end
        a_err_next  = dec_err;
        a_size_next = dim_at(ax_idx, dim_reg[0], dim_reg[1], dim_reg[2], dim_reg[3]);
        for (int i = 0; i < 3; i++)
        begin
            a_fac_next[i] = fac[i];
        end

        b_err_next  = a_err_reg;
        b_size_next = a_size_reg;
        b_p12_next  = clamp_prod(PW'(a_fac_reg[0]) * PW'(a_fac_reg[1]));
        b_f3_next   = a_fac_reg[2];

        c_inner_full = clamp_prod(PW'(b_p12_reg) * PW'(b_f3_reg));
        c_err_next   = b_err_reg || (c_inner_full == IW'(CLAMP));
        c_size_next  = b_size_reg;
        c_inner_next = c_inner_full;
    end

    always_ff @(posedge clk)
    begin
        a_err_reg   <= a_err_next;
        a_size_reg  <= a_size_next;
        for (int i = 0; i < 3; i++)
        begin
            a_fac_reg[i] <= a_fac_next[i];
        end
        b_err_reg   <= b_err_next;
        b_size_reg  <= b_size_next;
        b_p12_reg   <= b_p12_next;
        b_f3_reg    <= b_f3_next;
        c_err_reg   <= c_err_next;
        c_size_reg  <= c_size_next;
        c_inner_reg <= c_inner_next;
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_move;
    logic accept;

    assign s1_move    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = (settle_reg != '0) || (s1_valid_reg && !s1_move);
    assign accept     = item_valid && !item_stall;

    // ------------------------------------------------------------------
    // position tracking and stage 1 load
    // ------------------------------------------------------------------
    logic [AW-1:0]          ip_reg, ip_next;
    dim_t                   ap_reg, ap_next;
    logic [DATA_WIDTH-1:0]  flat_reg, flat_next;

    logic [DATA_WIDTH-1:0]  s1_data_reg, s1_data_next;
    logic                   s1_direct_reg, s1_direct_next;
    logic                   s1_write_reg, s1_write_next;
    logic                   s1_err_reg, s1_err_next;
    logic                   s1_last_reg, s1_last_next;
    logic [AW-1:0]          s1_addr_reg, s1_addr_next;

    logic [DATA_WIDTH-1:0]  elem;
    logic                   restart;
    logic [AW-1:0]          ip_eff;
    dim_t                   ap_eff;
    logic [AW:0]            ip_inc;
    logic [DIM_WIDTH:0]     ap_inc;
    logic                   axis_err;
    logic [DATA_WIDTH-1:0]  s1_sum;

    always_comb
    begin
        elem     = element[DATA_WIDTH-1:0];
        axis_err = !flatten_reg && c_err_reg;
        restart  = (IW'(ip_reg) >= c_inner_reg) || (ap_reg >= c_size_reg);
        ip_eff   = restart ? '0 : ip_reg;
        ap_eff   = restart ? '0 : ap_reg;
        ip_inc   = {1'b0, ip_eff} + (AW+1)'(1);
        ap_inc   = {1'b0, ap_eff} + (DIM_WIDTH+1)'(1);

        ip_next        = ip_reg;
        ap_next        = ap_reg;
        flat_next      = flat_reg;
        s1_valid_next  = s1_move ? 1'b0 : s1_valid_reg;
        s1_data_next   = s1_data_reg;
        s1_direct_next = s1_direct_reg;
        s1_write_next  = s1_write_reg;
        s1_err_next    = s1_err_reg;
        s1_last_next   = s1_last_reg;
        s1_addr_next   = s1_addr_reg;

        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_last_next  = end_of_array;
            s1_err_next   = axis_err;
            s1_addr_next  = ip_eff;
            if (flatten_reg)
            begin
                flat_next      = flat_reg + elem;
                s1_data_next   = flat_reg + elem;
                s1_direct_next = 1'b1;
                s1_write_next  = 1'b0;
            end
            else if (axis_err)
            begin
                s1_data_next   = elem;
                s1_direct_next = 1'b1;
                s1_write_next  = 1'b0;
            end
            else
            begin
                s1_data_next   = elem;
                s1_direct_next = (ap_eff == '0);
                s1_write_next  = 1'b1;
                if (IW'(ip_inc) >= c_inner_reg)
                begin
                    ip_next = '0;
                    ap_next = (ap_inc >= {1'b0, c_size_reg}) ? '0 : ap_inc[DIM_WIDTH-1:0];
                end
                else
                begin
                    ip_next = ip_inc[AW-1:0];
                    ap_next = ap_eff;
                end
            end
            if (end_of_array)
            begin
                ip_next   = '0;
                ap_next   = '0;
                flat_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg        <= '0;
            ap_reg        <= '0;
            flat_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ip_reg        <= ip_next;
            ap_reg        <= ap_next;
            flat_reg      <= flat_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg   <= s1_data_next;
        s1_direct_reg <= s1_direct_next;
        s1_write_reg  <= s1_write_next;
        s1_err_reg    <= s1_err_next;
        s1_last_reg   <= s1_last_next;
        s1_addr_reg   <= s1_addr_next;
    end

    // ------------------------------------------------------------------
    // line store with write-to-read forwarding
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0]  store_mem [MAX_INNER];
    logic [DATA_WIDTH-1:0]  rd_reg;
    logic                   fwd_hit_reg, fwd_hit_next;
    logic [DATA_WIDTH-1:0]  fwd_val_reg, fwd_val_next;
    logic [DATA_WIDTH-1:0]  base;
    logic                   store_we;

    assign store_we     = s1_move && s1_write_reg && !s1_err_reg;
    assign base         = fwd_hit_reg ? fwd_val_reg : rd_reg;
    assign s1_sum       = s1_direct_reg ? s1_data_reg : base + s1_data_reg;
    assign fwd_hit_next = accept ? (store_we && (s1_addr_reg == ip_eff)) : fwd_hit_reg;
    assign fwd_val_next = accept ? s1_sum : fwd_val_reg;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[s1_addr_reg] <= s1_sum;
        end
        if (accept)
        begin
            rd_reg <= store_mem[ip_eff];
        end
        fwd_hit_reg <= fwd_hit_next;
        fwd_val_reg <= fwd_val_next;
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic signed [ELEM_WIDTH-1:0] sum_reg, sum_next;
    logic                         final_reg, final_next;
    logic                         err_reg, err_next;

    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        sum_next       = sum_reg;
        final_next     = final_reg;
        err_next       = err_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
            sum_next       = s1_err_reg ? '0 : ELEM_WIDTH'($signed(s1_sum));
            final_next     = s1_last_reg;
            err_next       = s1_err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        final_reg <= final_next;
        err_reg   <= err_next;
    end

    assign result_valid = out_valid_reg;
    assign sum          = sum_reg;
    assign final_res    = final_reg;
    assign shape_error  = err_reg;

endmodule
